[rtl/core/b64e_pkg.sv]
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
// No dependencies; used by every module under rtl/core.
package b64e_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned SEXTET_W     = 6;
  localparam int unsigned LEFT_W       = 4;
  localparam int unsigned SLOTS        = 4;
  localparam int unsigned SLOT_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR   = 7'h3D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;

  // One queue entry: all characters one input byte produces, in emit order.
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [SLOT_IDX_W-1:0]        last_idx;
    logic                         msg_last;
  } entry_t;

  function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] s);
    logic [CHAR_W-1:0] code;
    logic [CHAR_W-1:0] s_ext;
    s_ext = {1'b0, s};
    if (s < 6'd26) begin
      code = CHAR_UPPER + s_ext;
    end else if (s < 6'd52) begin
      code = CHAR_LOWER + s_ext - 7'd26;
    end else if (s < 6'd62) begin
      code = CHAR_DIGIT + s_ext - 7'd52;
    end else if (s == 6'd62) begin
      code = CHAR_PLUS;
    end else begin
      code = CHAR_SLASH;
    end
    return code;
  endfunction

endpackage

[rtl/core/b64e_front.sv]
// Front end: accepts bytes, regroups them into sextets, adds flush and padding.
// Depends on b64e_pkg; writes one b64e_pkg::entry_t per accepted byte.
module b64e_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [b64e_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           last_byte,
  output b64e_pkg::entry_t               entry
);

  typedef enum logic [1:0] {
    CNT0 = 2'd0,
    CNT2 = 2'd1,
    CNT4 = 2'd2
  } left_cnt_t;

  left_cnt_t                         cnt_r, cnt_nxt;
  logic [b64e_pkg::LEFT_W-1:0]       left_r, left_nxt;
  logic [1:0]                        mod_r, mod_nxt;
  logic [b64e_pkg::SEXTET_W-1:0]     s0, s1;
  logic [1:0]                        nchar;
  logic [1:0]                        mod_sum;
  logic [1:0]                        pads;
  logic [2:0]                        total;

  always_comb begin
    case (cnt_r)
      CNT2: begin
        s0       = {left_r[1:0], data_byte[7:4]};
        s1       = {data_byte[3:0], 2'b00};
        left_nxt = data_byte[3:0];
        cnt_nxt  = CNT4;
        nchar    = last_byte ? 2'd2 : 2'd1;
      end
      CNT4: begin
        s0       = {left_r, data_byte[7:6]};
        s1       = data_byte[5:0];
        left_nxt = '0;
        cnt_nxt  = CNT0;
        nchar    = 2'd2;
      end
      default: begin
        s0       = data_byte[7:2];
        s1       = {data_byte[1:0], 4'b0000};
        left_nxt = {2'b00, data_byte[1:0]};
        cnt_nxt  = CNT2;
        nchar    = last_byte ? 2'd2 : 2'd1;
      end
    endcase

    mod_sum = mod_r + nchar;
    // Padding brings the message length up to a multiple of four.
    pads    = last_byte ? (2'd0 - mod_sum) : 2'd0;
    total   = {1'b0, nchar} + {1'b0, pads};
    mod_nxt = last_byte ? 2'd0 : mod_sum;

    entry.chars[0] = b64e_pkg::sextet_to_char(s0);
    entry.chars[1] = (nchar == 2'd2) ? b64e_pkg::sextet_to_char(s1) : b64e_pkg::PAD_CHAR;
    entry.chars[2] = b64e_pkg::PAD_CHAR;
    entry.chars[3] = b64e_pkg::PAD_CHAR;
    entry.last_idx = 2'(total - 3'd1);
    entry.msg_last = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT0;
      left_r <= '0;
      mod_r  <= '0;
    end else if (accept) begin
      cnt_r  <= last_byte ? CNT0 : cnt_nxt;
      left_r <= last_byte ? '0 : left_nxt;
      mod_r  <= mod_nxt;
    end
  end

endmodule

[rtl/core/b64e_queue.sv]
// Small register queue of character entries between the front and back ends.
// Depends on b64e_pkg for the entry type.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  b64e_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output b64e_pkg::entry_t rd_data,
  output logic             empty
);

  // DEPTH must be at least 2.
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  b64e_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r == CNT_MAX);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/b64e_back.sv]
// Back end: walks the head entry one character per cycle into the output register
// unless an unpopped character is held. Depends on b64e_pkg for entry type and width.
module b64e_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  b64e_pkg::entry_t              head,
  input  logic                          head_valid,
  output logic                          head_done,
  output logic                          empty,
  input  logic                          pop,
  output logic [b64e_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last_char
);

  logic [b64e_pkg::SLOT_IDX_W-1:0] idx_r;
  logic                            valid_r;
  logic [b64e_pkg::CHAR_W-1:0]     char_r;
  logic                            last_r;
  logic                            load;
  logic                            at_end;

  // With a head entry, the output reg refills in the same cycle its word is taken.
  assign load      = head_valid && (!valid_r || pop);
  assign at_end    = (idx_r == head.last_idx);
  assign head_done = load && at_end;

  assign empty         = !valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      last_r <= head.msg_last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= at_end ? '0 : idx_r + 1'b1;
        valid_r <= 1'b1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/base64_stream_encoder_top.sv]
// Base64 stream encoder (standard alphabet, '=' padding). A byte is accepted in
// any cycle in which full is low; it yields one or two characters, and a byte
// marked last adds the flush character and padding, up to four in all. The
// result side gives one character per cycle from an output register while pop
// is high, so the single-character result port sets the pace; a two-entry queue
// between the byte front end and the character back end lets either side stall,
// until the queue fills or drains, without stopping the other.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [b64e_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_last_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [b64e_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last_char
);

  b64e_pkg::entry_t wr_entry;
  b64e_pkg::entry_t head;
  logic             q_empty;
  logic             head_done;
  logic             accept;

  assign accept = push && !full;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .entry     (wr_entry)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (wr_entry),
    .full    (full),
    .rd_en   (head_done),
    .rd_data (head),
    .empty   (q_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (!q_empty),
    .head_done     (head_done),
    .empty         (empty),
    .pop           (pop),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

[rtl/core/b64e_checker.sv]
// Port-level checks for the Base64 stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_top.
module b64e_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [b64e_pkg::CHAR_W-1:0]   out_char,
  input logic                          out_last_char
);

  // After reset both sides start idle.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queue not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_last_char)))
    else $error("stalled word changed");

  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_char >= 7'h41 && out_char <= 7'h5A) ||
                (out_char >= 7'h61 && out_char <= 7'h7A) ||
                (out_char >= 7'h30 && out_char <= 7'h39) ||
                out_char == b64e_pkg::CHAR_PLUS || out_char == b64e_pkg::CHAR_SLASH ||
                out_char == b64e_pkg::PAD_CHAR))
    else $error("character outside the alphabet");

  // Padding runs to the end of the message with no gap.
  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_char == b64e_pkg::PAD_CHAR && !out_last_char)
      |=> (!empty && out_char == b64e_pkg::PAD_CHAR))
    else $error("padding interrupted");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .out_char      (out_char),
  .out_last_char (out_last_char)
);
